// File: rtl/indexed_insert_erase_array_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the indexed insert/erase array unit
// Concurrent assertion wrappers that compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef INDEXED_INSERT_ERASE_ARRAY_UNIT_MACROS_SVH
`define INDEXED_INSERT_ERASE_ARRAY_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IIEA_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define IIEA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) ante |=> cons) else $error(msg);
`else
`define IIEA_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define IIEA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

// File: rtl/iiea_pkg.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array package
// Field widths, request and status codes and the cell control type.
// ----------------------------------------------------------------------------
package iiea_pkg;

  localparam int TYPE_W = 3;
  localparam int IDX_W  = 9;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 9;
  localparam int ST_W   = 2;
  localparam int SIZE_W = 9;
  localparam int CAP_W  = 10;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int RD_GROUP       = 16;

  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_ERASE  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_GET    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_SET    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_QUERY  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_SHIFT  = 2'd2,
    CM_SET    = 2'd3
  } cell_mode_t;

endpackage

// File: rtl/iiea_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface iiea_req_if;
  logic                            valid;
  logic                            ready;
  logic [iiea_pkg::TYPE_W-1:0]     req_type;
  logic [iiea_pkg::IDX_W-1:0]      item_index;
  logic signed [iiea_pkg::VAL_W-1:0] item_value;
  logic [iiea_pkg::CNT_W-1:0]      erase_count;
  logic                            run_last;

  modport source (output valid, req_type, item_index, item_value, erase_count, run_last,
                  input ready);
  modport sink (input valid, req_type, item_index, item_value, erase_count, run_last,
                output ready);
endinterface

// File: rtl/iiea_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface iiea_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [iiea_pkg::ST_W-1:0]         status;
  logic signed [iiea_pkg::VAL_W-1:0] read_value;
  logic [iiea_pkg::SIZE_W-1:0]       list_size;
  logic [iiea_pkg::CAP_W-1:0]        list_capacity;

  modport source (output valid, status, read_value, list_size, list_capacity, input ready);
  modport sink (input valid, status, read_value, list_size, list_capacity, output ready);
endinterface

// File: rtl/iiea_cell.sv
// ----------------------------------------------------------------------------
// Array cell
// Holds one list entry and takes its neighbor's word on insert or erase.
// ----------------------------------------------------------------------------
module iiea_cell #(
  parameter int DATA_WIDTH = iiea_pkg::DATA_WIDTH_DEF,
  parameter int POS_W      = iiea_pkg::IDX_W,
  parameter int CELL_IDX   = 0
) (
  input  logic                   clk,
  input  iiea_pkg::cell_mode_t   mode_i,
  input  logic [POS_W-1:0]       pos_i,
  input  logic [DATA_WIDTH-1:0]  wr_data_i,
  input  logic [DATA_WIDTH-1:0]  left_i,
  input  logic [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic [DATA_WIDTH-1:0]  hit_data_o
);

  localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_IDX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (mode_i)
      iiea_pkg::CM_HOLD: begin
        data_nxt = data_r;
      end
      iiea_pkg::CM_INSERT: begin
        if (MY_POS > pos_i) begin
          data_nxt = left_i;
        end else if (MY_POS == pos_i) begin
          data_nxt = wr_data_i;
        end
      end
      iiea_pkg::CM_SHIFT: begin
        if (MY_POS >= pos_i) begin
          data_nxt = right_i;
        end
      end
      iiea_pkg::CM_SET: begin
        if (MY_POS == pos_i) begin
          data_nxt = wr_data_i;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o     = data_r;
  assign hit_data_o = (MY_POS == pos_i) ? data_r : '0;

endmodule

// File: rtl/iiea_rd_tree.sv
// ----------------------------------------------------------------------------
// Read collection tree
// Two-level OR of the cells' selected words, registered per group of cells.
// ----------------------------------------------------------------------------
module iiea_rd_tree #(
  parameter int DEPTH      = iiea_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iiea_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic [DEPTH-1:0][DATA_WIDTH-1:0]  leaf_i,
  output logic [DATA_WIDTH-1:0]             rd_o
);

  localparam int GROUP = iiea_pkg::RD_GROUP;
  localparam int NG    = (DEPTH + GROUP - 1) / GROUP;

  logic [DATA_WIDTH-1:0] group_r   [NG];
  logic [DATA_WIDTH-1:0] group_nxt [NG];

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      group_nxt[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < DEPTH) begin
          group_nxt[g] = group_nxt[g] | leaf_i[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      group_r[g] <= group_nxt[g];
    end
  end

  always_comb begin
    rd_o = '0;
    for (int g = 0; g < NG; g++) begin
      rd_o = rd_o | group_r[g];
    end
  end

endmodule

// File: rtl/indexed_insert_erase_array_unit.sv
// ----------------------------------------------------------------------------
// Indexed insert/erase array unit
// Ordered word list in a chain of cells with insert, erase, get and set.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch and one result per request leaves on out_ch; both
// are valid/ready channels and a transfer happens when both are high.
// Insert, set, status queries and rejected requests have a registered
// result that shows on out_ch the cycle after the transfer, and a new
// request can be taken in the same cycle that the result is taken.
// A get has the cell hit collected through a registered OR tree before the
// result register. An erase of N entries, N after clamping, moves every entry
// of the cell chain at or above the position down by one place per cycle
// until they have moved N places. Its result is loaded at the transfer and
// shows while the shifting goes on; in_ch.ready stays low until it ends.
// If the receiver stalls, the result is held and no further request is taken
// until it leaves. Reset clears the size to zero, the capacity to one and
// closes any insert run; cell contents are not cleared and are never read
// before they are written.
// ----------------------------------------------------------------------------
`include "indexed_insert_erase_array_unit_macros.svh"

module indexed_insert_erase_array_unit #(
  parameter int DEPTH      = iiea_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = iiea_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  iiea_req_if.sink   in_ch,
  iiea_rsp_if.source out_ch
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = (CW > iiea_pkg::IDX_W) ? CW : iiea_pkg::IDX_W;
  localparam int CAPW = $clog2(2 * DEPTH) + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ERASE = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CAPW-1:0]  cap_r, cap_nxt;
  logic             run_active_r, run_active_nxt;
  logic             run_rej_r, run_rej_nxt;
  logic [PW-1:0]    cursor_r, cursor_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    shift_r, shift_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [iiea_pkg::ST_W-1:0]      out_status_r, out_status_nxt;
  logic [iiea_pkg::VAL_W-1:0]     out_read_r, out_read_nxt;
  logic [iiea_pkg::SIZE_W-1:0]    out_size_r, out_size_nxt;
  logic [iiea_pkg::CAP_W-1:0]     out_cap_r, out_cap_nxt;

  logic                  in_fire;
  logic [PW-1:0]         idx_ext, cnt_ext, ins_cur, remain, ers_req, ers_n;
  logic                  ins_rej, idx_lt, full, ins_ok;
  logic                  load, ld_read;
  logic [iiea_pkg::ST_W-1:0] ld_status;
  iiea_pkg::cell_mode_t  cell_mode;
  logic [PW-1:0]         cell_pos;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] rd_data;

  logic [DATA_WIDTH-1:0]             cell_data [DEPTH];
  logic [DEPTH-1:0][DATA_WIDTH-1:0]  hit_data;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);

  assign idx_ext = PW'(in_ch.item_index);
  assign cnt_ext = PW'(cnt_r);
  assign ins_cur = run_active_r ? cursor_r : idx_ext;
  assign ins_rej = run_active_r ? run_rej_r : (idx_ext > cnt_ext);
  assign idx_lt  = idx_ext < cnt_ext;
  assign full    = cnt_r == CW'(DEPTH);
  assign remain  = cnt_ext - idx_ext;
  assign ers_req = PW'(in_ch.erase_count);
  assign ers_n   = (ers_req > remain) ? remain : ers_req;
  assign wr_data = DATA_WIDTH'($unsigned(in_ch.item_value));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cap_nxt        = cap_r;
    run_active_nxt = run_active_r;
    run_rej_nxt    = run_rej_r;
    cursor_nxt     = cursor_r;
    pos_nxt        = pos_r;
    shift_nxt      = shift_r;
    cell_mode      = iiea_pkg::CM_HOLD;
    cell_pos       = idx_ext;
    load           = 1'b0;
    ld_read        = 1'b0;
    ld_status      = iiea_pkg::ST_OK;
    ins_ok         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type != iiea_pkg::REQ_INSERT) begin
            run_active_nxt = 1'b0;
            run_rej_nxt    = 1'b0;
          end
          unique case (in_ch.req_type)
            iiea_pkg::REQ_INSERT: begin
              load     = 1'b1;
              cell_pos = ins_cur;
              if (ins_rej) begin
                ld_status = iiea_pkg::ST_RANGE;
              end else if (full) begin
                ld_status = iiea_pkg::ST_FULL;
              end else if (ins_cur > cnt_ext) begin
                ld_status = iiea_pkg::ST_RANGE;
              end else begin
                ins_ok    = 1'b1;
                cell_mode = iiea_pkg::CM_INSERT;
                cnt_nxt   = CW'(cnt_r + 1'b1);
                if (cap_r <= CAPW'(cnt_r + 1'b1)) begin
                  cap_nxt = cap_r << 1;
                end
              end
              cursor_nxt = ins_ok ? PW'(ins_cur + 1'b1) : ins_cur;
              if (in_ch.run_last) begin
                run_active_nxt = 1'b0;
                run_rej_nxt    = 1'b0;
              end else begin
                run_active_nxt = 1'b1;
                run_rej_nxt    = ins_rej;
              end
            end
            iiea_pkg::REQ_ERASE: begin
              load = 1'b1;
              if (!idx_lt) begin
                ld_status = iiea_pkg::ST_RANGE;
              end else begin
                cnt_nxt = cnt_r - CW'(ers_n);
                if (ers_n != '0) begin
                  state_nxt = S_ERASE;
                  shift_nxt = CW'(ers_n);
                  pos_nxt   = idx_ext;
                end
              end
            end
            iiea_pkg::REQ_GET: begin
              if (idx_lt) begin
                state_nxt = S_READ;
              end else begin
                load      = 1'b1;
                ld_status = iiea_pkg::ST_RANGE;
              end
            end
            iiea_pkg::REQ_SET: begin
              load = 1'b1;
              if (idx_lt) begin
                cell_mode = iiea_pkg::CM_SET;
              end else begin
                ld_status = iiea_pkg::ST_RANGE;
              end
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_ERASE: begin
        cell_mode = iiea_pkg::CM_SHIFT;
        cell_pos  = pos_r;
        shift_nxt = shift_r - 1'b1;
        if (shift_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        load      = 1'b1;
        ld_read   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_read_nxt   = out_read_r;
    out_size_nxt   = out_size_r;
    out_cap_nxt    = out_cap_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ld_status;
      out_read_nxt   = ld_read ? iiea_pkg::VAL_W'(rd_data) : '0;
      out_size_nxt   = iiea_pkg::SIZE_W'(cnt_nxt);
      out_cap_nxt    = iiea_pkg::CAP_W'(cap_nxt);
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      cap_r        <= CAPW'(1);
      run_active_r <= 1'b0;
      run_rej_r    <= 1'b0;
      cursor_r     <= '0;
      pos_r        <= '0;
      shift_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cap_r        <= cap_nxt;
      run_active_r <= run_active_nxt;
      run_rej_r    <= run_rej_nxt;
      cursor_r     <= cursor_nxt;
      pos_r        <= pos_nxt;
      shift_r      <= shift_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_read_r   <= out_read_nxt;
    out_size_r   <= out_size_nxt;
    out_cap_r    <= out_cap_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    iiea_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .POS_W      (PW),
      .CELL_IDX   (i)
    ) u_cell (
      .clk        (clk),
      .mode_i     (cell_mode),
      .pos_i      (cell_pos),
      .wr_data_i  (wr_data),
      .left_i     (left_d),
      .right_i    (right_d),
      .data_o     (cell_data[i]),
      .hit_data_o (hit_data[i])
    );
  end

  iiea_rd_tree #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_rd_tree (
    .clk    (clk),
    .leaf_i (hit_data),
    .rd_o   (rd_data)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.read_value    = out_read_r;
  assign out_ch.list_size     = out_size_r;
  assign out_ch.list_capacity = out_cap_r;

  `IIEA_ASSERT(a_cap_above_size, clk, rst_n, cap_r > CAPW'(cnt_r), "capacity not above size")
  `IIEA_ASSERT(a_size_bound, clk, rst_n, cnt_r <= CW'(DEPTH), "size exceeds depth")
  `IIEA_ASSERT(a_erase_count, clk, rst_n, (state_r == S_ERASE) |-> (shift_r != '0), "erase shift count is zero")
  `IIEA_ASSERT(a_run_flags, clk, rst_n, !run_active_r |-> !run_rej_r, "rejected run flag without open run")
  `IIEA_ASSERT_NEXT(a_get_read, clk, rst_n, in_fire && (in_ch.req_type == iiea_pkg::REQ_GET) && idx_lt, (state_r == S_READ) && !out_valid_r, "get did not enter read cycle")

endmodule

// File: sim/indexed_insert_erase_array_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/erase array unit testbench
// Drives insert runs, erases, gets, sets and status queries with random
// gaps and stalls. A tracker keeps its own copy of the list and checks
// every result field against the result it works out for each transfer.
// ----------------------------------------------------------------------------
module indexed_insert_erase_array_unit_tb;

  localparam int DEPTH       = iiea_pkg::DEPTH_DEF;
  localparam int AW          = $clog2(DEPTH);
  localparam int DRAIN       = DEPTH + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TOTAL_ITEMS = 550;

  typedef enum int {PH_MIX, PH_FILL, PH_SHRINK} phase_t;

  typedef struct packed {
    logic [iiea_pkg::TYPE_W-1:0] req_type;
    logic [iiea_pkg::IDX_W-1:0]  item_index;
    logic [iiea_pkg::VAL_W-1:0]  item_value;
    logic [iiea_pkg::CNT_W-1:0]  erase_count;
    logic                        run_last;
  } list_req_t;

  typedef struct packed {
    logic [iiea_pkg::ST_W-1:0]   status;
    logic [iiea_pkg::VAL_W-1:0]  read_value;
    logic [iiea_pkg::SIZE_W-1:0] list_size;
    logic [iiea_pkg::CAP_W-1:0]  list_capacity;
  } list_rsp_t;

  class list_tracker_t;
    logic [iiea_pkg::VAL_W-1:0]  cells [DEPTH];
    logic [iiea_pkg::SIZE_W-1:0] held;
    logic [iiea_pkg::CAP_W-1:0]  cap;
    logic                        run_open;
    logic                        run_bad;
    logic [iiea_pkg::IDX_W-1:0]  cursor;
    list_rsp_t                   pending_rsp [$];
    int                          errors;
    int                          results;
    int                          full_drops;

    function new();
      held       = '0;
      cap        = iiea_pkg::CAP_W'(1);
      run_open   = 1'b0;
      run_bad    = 1'b0;
      cursor     = '0;
      errors     = 0;
      results    = 0;
      full_drops = 0;
    endfunction

    function void note_request(list_req_t r);
      list_rsp_t e;
      int        base;
      int        n;
      e.status     = iiea_pkg::ST_OK;
      e.read_value = '0;
      if (r.req_type != iiea_pkg::REQ_INSERT) begin
        run_open = 1'b0;
        run_bad  = 1'b0;
      end
      case (r.req_type)
        iiea_pkg::REQ_INSERT: begin
          if (!run_open) begin
            run_open = 1'b1;
            run_bad  = (r.item_index > held);
            cursor   = r.item_index;
          end
          if (run_bad) begin
            e.status = iiea_pkg::ST_RANGE;
          end else if (held >= DEPTH) begin
            e.status = iiea_pkg::ST_FULL;
            full_drops++;
          end else if (cursor > held) begin
            e.status = iiea_pkg::ST_RANGE;
          end else begin
            for (int i = int'(held); i > int'(cursor); i--) cells[AW'(i)] = cells[AW'(i - 1)];
            cells[AW'(cursor)] = r.item_value;
            held++;
            cursor++;
            while (cap <= held) cap = cap << 1;
          end
          if (r.run_last) begin
            run_open = 1'b0;
            run_bad  = 1'b0;
          end
        end
        iiea_pkg::REQ_ERASE: begin
          if (r.item_index >= held) begin
            e.status = iiea_pkg::ST_RANGE;
          end else begin
            base = int'(r.item_index);
            n    = int'(r.erase_count);
            if (n > int'(held) - base) n = int'(held) - base;
            for (int i = base + n; i < int'(held); i++) cells[AW'(i - n)] = cells[AW'(i)];
            held = held - iiea_pkg::SIZE_W'(n);
          end
        end
        iiea_pkg::REQ_GET: begin
          if (r.item_index < held) e.read_value = cells[AW'(r.item_index)];
          else e.status = iiea_pkg::ST_RANGE;
        end
        iiea_pkg::REQ_SET: begin
          if (r.item_index < held) cells[AW'(r.item_index)] = r.item_value;
          else e.status = iiea_pkg::ST_RANGE;
        end
        default: ;
      endcase
      e.list_size     = held;
      e.list_capacity = cap;
      pending_rsp.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 50)
        $display("%s mismatch at result %0d: got 0x%0h, expected 0x%0h",
                 what, results, got, want);
    endtask

    task check_result(list_rsp_t got);
      list_rsp_t want;
      results++;
      if (pending_rsp.size() == 0) begin
        report("unexpected result", '0, '0);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.read_value !== want.read_value)
        report("read_value", got.read_value, want.read_value);
      if (got.list_size !== want.list_size)
        report("list_size", 32'(got.list_size), 32'(want.list_size));
      if (got.list_capacity !== want.list_capacity)
        report("list_capacity", 32'(got.list_capacity), 32'(want.list_capacity));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   sent;
  int   cycles;

  list_tracker_t sb;

  iiea_req_if req_if ();
  iiea_rsp_if rsp_if ();

  indexed_insert_erase_array_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [iiea_pkg::TYPE_W-1:0] kind,
                           input logic [iiea_pkg::IDX_W-1:0] idx,
                           input logic [iiea_pkg::VAL_W-1:0] val,
                           input logic [iiea_pkg::CNT_W-1:0] cnt,
                           input logic last);
    list_req_t r;
    r = '{kind, idx, val, cnt, last};
    while (!(sent >= 200 && sent < 330) && $urandom_range(99) < 21) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= kind;
    req_if.item_index  <= idx;
    req_if.item_value  <= val;
    req_if.erase_count <= cnt;
    req_if.run_last    <= last;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sb.note_request(r);
    sent++;
  endtask

  task automatic send_run(input logic [iiea_pkg::IDX_W-1:0] start, input int len,
                          input logic closed);
    for (int k = 0; k < len; k++)
      send_item(iiea_pkg::REQ_INSERT,
                (k == 0) ? start : iiea_pkg::IDX_W'($urandom_range(0, 511)), $urandom,
                iiea_pkg::CNT_W'($urandom_range(0, 256)), closed && (k == len - 1));
  endtask

  task automatic random_step(input phase_t phase);
    int                         roll;
    int                         lim;
    int                         t_ins;
    int                         t_era;
    int                         t_get;
    int                         t_set;
    int                         pick;
    logic [iiea_pkg::IDX_W-1:0] start;
    logic [iiea_pkg::IDX_W-1:0] base;
    logic [iiea_pkg::CNT_W-1:0] cnt;
    lim  = int'(sb.held);
    roll = $urandom_range(99);
    case (phase)
      PH_FILL: begin
        t_ins = 88; t_era = 88; t_get = 94; t_set = 100;
      end
      PH_SHRINK: begin
        t_ins = 30; t_era = 55; t_get = 72; t_set = 87;
      end
      default: begin
        t_ins = 40; t_era = 55; t_get = 72; t_set = 87;
      end
    endcase
    if ($urandom_range(99) < 85)
      base = iiea_pkg::IDX_W'($urandom_range(0, (lim == 0) ? 0 : lim - 1));
    else base = iiea_pkg::IDX_W'($urandom_range(0, 511));
    pick = $urandom_range(99);
    if (pick < 70) cnt = iiea_pkg::CNT_W'($urandom_range(0, 8));
    else if (pick < 92) cnt = iiea_pkg::CNT_W'($urandom_range(0, 255));
    else cnt = 9'd256;
    if (roll < t_ins) begin
      if ($urandom_range(99) < 10) start = iiea_pkg::IDX_W'($urandom_range(lim + 1, 511));
      else start = iiea_pkg::IDX_W'($urandom_range(0, lim));
      send_run(start, (phase == PH_FILL) ? $urandom_range(4, 20) : $urandom_range(1, 6),
               $urandom_range(99) < 90);
    end else if (roll < t_era) begin
      send_item(iiea_pkg::REQ_ERASE, base, $urandom, cnt, 1'($urandom_range(1)));
    end else if (roll < t_get) begin
      send_item(iiea_pkg::REQ_GET, base, $urandom, cnt, 1'($urandom_range(1)));
    end else if (roll < t_set) begin
      send_item(iiea_pkg::REQ_SET, base, $urandom, cnt, 1'($urandom_range(1)));
    end else begin
      send_item(iiea_pkg::REQ_QUERY, base, $urandom, cnt, 1'($urandom_range(1)));
    end
  endtask

  initial begin : receive_proc
    list_rsp_t got;
    int        hold_left;
    logic      held_off;
    hold_left = 0;
    held_off  = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.status, rsp_if.read_value, rsp_if.list_size, rsp_if.list_capacity};
        sb.check_result(got);
      end
      if (!held_off && sb.results == 100) begin
        hold_left = 300;
        held_off  = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (sb.results >= 350 && sb.results < 470) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin
    sb    = new();
    sent  = 0;
    rst_n = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = iiea_pkg::REQ_QUERY;
    req_if.item_index  = '0;
    req_if.item_value  = '0;
    req_if.erase_count = '0;
    req_if.run_last    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(iiea_pkg::REQ_QUERY, '0, '0, '0, 1'b1);
    send_item(iiea_pkg::REQ_GET, '0, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_ERASE, '0, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_SET, '0, 32'h5a5a5a5a, '0, 1'b0);
    send_run(9'd5, 3, 1'b1);
    send_item(iiea_pkg::REQ_INSERT, '0, 32'h7fffffff, '0, 1'b1);
    send_item(iiea_pkg::REQ_INSERT, '0, 32'h80000000, '0, 1'b1);
    send_item(iiea_pkg::REQ_INSERT, 9'd1, 32'h00000000, '0, 1'b0);
    send_item(iiea_pkg::REQ_INSERT, 9'd511, 32'hffffffff, 9'd256, 1'b0);
    send_item(iiea_pkg::REQ_INSERT, '0, 32'h12345678, '0, 1'b1);
    send_item(iiea_pkg::REQ_GET, '0, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_GET, 9'd4, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_GET, 9'd5, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_SET, 9'd4, 32'hffffffff, '0, 1'b0);
    send_item(iiea_pkg::REQ_SET, 9'd511, 32'h00000001, '0, 1'b0);
    send_item(iiea_pkg::REQ_INSERT, 9'd5, 32'hcafef00d, '0, 1'b0);
    send_item(iiea_pkg::REQ_QUERY, '0, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_INSERT, '0, 32'h0badcafe, '0, 1'b1);
    send_item(iiea_pkg::REQ_ERASE, 9'd1, '0, '0, 1'b0);
    send_item(iiea_pkg::REQ_ERASE, 9'd2, '0, 9'd256, 1'b0);
    send_item(iiea_pkg::REQ_ERASE, 9'd511, '0, 9'd1, 1'b0);
    send_item(iiea_pkg::REQ_GET, 9'd1, '0, '0, 1'b0);

    while (sent < 175) random_step(PH_MIX);
    while (sb.held < DEPTH || sb.full_drops < 20) random_step(PH_FILL);
    while (sent < TOTAL_ITEMS) random_step(PH_SHRINK);
    req_if.valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: indexed_insert_erase_array_unit.f
+incdir+rtl
rtl/iiea_pkg.sv
rtl/iiea_req_if.sv
rtl/iiea_rsp_if.sv
rtl/iiea_cell.sv
rtl/iiea_rd_tree.sv
rtl/indexed_insert_erase_array_unit.sv
sim/indexed_insert_erase_array_unit_tb.sv
